// ----- sv/brb_pkg.sv -----
package brb_pkg;

    // fixed field widths of the channel words
    localparam int CFG_W   = 4;
    localparam int COUNT_W = 13;
    localparam int DATA_W  = 64;
    localparam int OFF_W   = 12;
    localparam int SIZE_W  = 13;

    // widest ring position and widest chunk count that the entry can carry
    localparam int POS_MAX_W = 20;
    localparam int CNT_W     = 4;

    // front-to-back queue holds 2**QUEUE_LOG2 entries
    localparam int QUEUE_LOG2 = 1;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 4'd12;

    typedef enum logic [1:0] {
        REQ_WRITE      = 2'd0,
        REQ_READ       = 2'd1,
        REQ_DESC_READ  = 2'd2,
        REQ_DESC_WRITE = 2'd3
    } req_type_t;

    // memory operation the back end carries out
    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } op_t;

    // classified request, front to back
    typedef struct packed {
        op_t                  op;
        logic                 ok;
        logic [CNT_W-1:0]     count;
        logic [POS_MAX_W-1:0] start;
        logic [POS_MAX_W-1:0] mask;
        logic [DATA_W-1:0]    wdata;
        logic [OFF_W-1:0]     r1_off;
        logic [SIZE_W-1:0]    r1_size;
        logic [SIZE_W-1:0]    r2_size;
    } entry_t;

endpackage

// ----- sv/brb_if.sv -----
// request channel
interface brb_req_if;
    import brb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [COUNT_W-1:0]    byte_count;
    logic [DATA_W-1:0]     write_data;

    modport source (output valid, req_type, byte_count, write_data, input ready);
    modport sink   (input valid, req_type, byte_count, write_data, output ready);
endinterface

// result channel
interface brb_rsp_if;
    import brb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  ok;
    logic [DATA_W-1:0]     read_data;
    logic [OFF_W-1:0]      region1_offset;
    logic [SIZE_W-1:0]     region1_size;
    logic [SIZE_W-1:0]     region2_size;

    modport source (output valid, ok, read_data, region1_offset, region1_size,
                    region2_size, input ready);
    modport sink   (input valid, ok, read_data, region1_offset, region1_size,
                    region2_size, output ready);
endinterface

// ----- sv/brb_front.sv -----
module brb_front #(
    parameter int DEPTH_LOG2  = 12,
    parameter int CHUNK_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [brb_pkg::CFG_W-1:0]   cfg_wr_data,
    brb_req_if.sink                     req,
    output logic                        push_valid,
    input  logic                        push_ready,
    output brb_pkg::entry_t             push_entry
);
    import brb_pkg::*;

    localparam int SZ_W  = DEPTH_LOG2 + 1;
    localparam int CMP_W = (SZ_W > COUNT_W) ? SZ_W : COUNT_W;
    localparam logic [4:0] DEPTH_L = 5'(DEPTH_LOG2);

    logic [CFG_W-1:0]      size_log2_reg;
    logic [DEPTH_LOG2-1:0] rd_off_reg, rd_off_next;
    logic [DEPTH_LOG2-1:0] wr_off_reg, wr_off_next;
    logic [SZ_W-1:0]       fill_reg, fill_next;

    logic [4:0]            eff_l;
    logic [SZ_W-1:0]       ring_size;
    logic [DEPTH_LOG2-1:0] ring_mask;
    logic [SZ_W-1:0]       space;
    logic [CMP_W-1:0]      count_x;
    logic                  fits_chunk;
    logic [CNT_W-1:0]      cnt_short;
    logic [CMP_W-1:0]      avail_x;
    logic [DEPTH_LOG2-1:0] desc_off;
    logic [SZ_W-1:0]       tail;
    logic [CMP_W-1:0]      first;
    logic                  push;

    assign req.ready  = push_ready;
    assign push_valid = req.valid;
    assign push       = req.valid && push_ready;

    // ring geometry from the size register, clamped to between 1 and the built depth
    always_comb
    begin
        if (size_log2_reg == '0)
            eff_l = 5'd1;
        else if ({1'b0, size_log2_reg} > DEPTH_L)
            eff_l = DEPTH_L;
        else
            eff_l = {1'b0, size_log2_reg};
        ring_size = SZ_W'(1) << eff_l;
        ring_mask = DEPTH_LOG2'(ring_size - SZ_W'(1));
        space     = ring_size - fill_reg;
    end

    // classify the request, work out position updates and describe split
    always_comb
    begin
        count_x    = CMP_W'(req.byte_count);
        fits_chunk = req.byte_count <= COUNT_W'(CHUNK_BYTES);
        cnt_short  = CNT_W'(req.byte_count);
        avail_x    = '0;
        desc_off   = '0;
        tail       = '0;
        first      = '0;

        rd_off_next = rd_off_reg;
        wr_off_next = wr_off_reg;
        fill_next   = fill_reg;

        push_entry         = '0;
        push_entry.op      = OP_NONE;
        push_entry.mask    = POS_MAX_W'(ring_mask);
        push_entry.wdata   = req.write_data;

        case (req_type_t'(req.req_type))
            REQ_WRITE:
            begin
                if (req.byte_count == '0)
                    push_entry.ok = 1'b1;
                else if (fits_chunk && count_x <= CMP_W'(space))
                begin
                    push_entry.op    = OP_WRITE;
                    push_entry.ok    = 1'b1;
                    push_entry.count = cnt_short;
                    push_entry.start = POS_MAX_W'(wr_off_reg);
                    wr_off_next = (wr_off_reg + DEPTH_LOG2'(cnt_short)) & ring_mask;
                    fill_next   = fill_reg + SZ_W'(cnt_short);
                end
            end
            REQ_READ:
            begin
                if (req.byte_count == '0)
                    push_entry.ok = 1'b1;
                else if (fits_chunk && count_x <= CMP_W'(fill_reg))
                begin
                    push_entry.op    = OP_READ;
                    push_entry.ok    = 1'b1;
                    push_entry.count = cnt_short;
                    push_entry.start = POS_MAX_W'(rd_off_reg);
                    rd_off_next = (rd_off_reg + DEPTH_LOG2'(cnt_short)) & ring_mask;
                    fill_next   = fill_reg - SZ_W'(cnt_short);
                end
            end
            REQ_DESC_READ, REQ_DESC_WRITE:
            begin
                if (req_type_t'(req.req_type) == REQ_DESC_READ)
                begin
                    avail_x  = CMP_W'(fill_reg);
                    desc_off = rd_off_reg;
                end
                else
                begin
                    avail_x  = CMP_W'(space);
                    desc_off = wr_off_reg;
                end
                tail  = ring_size - SZ_W'(desc_off);
                first = (count_x < CMP_W'(tail)) ? count_x : CMP_W'(tail);
                if (count_x <= avail_x)
                begin
                    push_entry.ok      = 1'b1;
                    push_entry.r1_off  = OFF_W'(desc_off);
                    push_entry.r1_size = SIZE_W'(first);
                    push_entry.r2_size = SIZE_W'(count_x - first);
                end
            end
            default:
            begin
                push_entry.ok = 1'b0;
            end
        endcase
    end

    // size register and ring positions; a size write rebinds the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RESET;
            rd_off_reg    <= '0;
            wr_off_reg    <= '0;
            fill_reg      <= '0;
        end
        else if (cfg_wr_en)
        begin
            size_log2_reg <= cfg_wr_data;
            rd_off_reg    <= '0;
            wr_off_reg    <= '0;
            fill_reg      <= '0;
        end
        else if (push)
        begin
            rd_off_reg <= rd_off_next;
            wr_off_reg <= wr_off_next;
            fill_reg   <= fill_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ring_size)
        else $error("ring fill exceeds ring size");

    a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ((rd_off_reg & ~ring_mask) == '0) && ((wr_off_reg & ~ring_mask) == '0))
        else $error("ring position outside ring in use");

endmodule

// ----- sv/brb_queue.sv -----
module brb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  brb_pkg::entry_t  in_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output brb_pkg::entry_t  out_entry
);
    import brb_pkg::*;

    localparam int QD = 1 << QUEUE_LOG2;

    entry_t                slot_reg [QD];
    logic [QUEUE_LOG2-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_LOG2:0]   count_reg;
    logic                  push, pop;

    assign in_ready  = count_reg != (QUEUE_LOG2+1)'(QD);
    assign out_valid = count_reg != '0;
    assign out_entry = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_entry;
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue occupancy lost a pushed word");

endmodule

// ----- sv/brb_back.sv -----
module brb_back #(
    parameter int DEPTH_LOG2  = 12,
    parameter int CHUNK_BYTES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    output logic             head_ready,
    input  brb_pkg::entry_t  head,
    brb_rsp_if.source        rsp
);
    import brb_pkg::*;

    // byte lanes, one small RAM each; a chunk never hits a lane twice
    localparam int LANE_LOG2 = (DEPTH_LOG2 < 3) ? DEPTH_LOG2 : 3;
    localparam int LANES     = 1 << LANE_LOG2;
    localparam int ROW_W     = DEPTH_LOG2 - LANE_LOG2;
    localparam int ROW_IW    = (ROW_W > 0) ? ROW_W : 1;
    localparam int ROWS      = 1 << ROW_W;

    logic [7:0]        mem [LANES][ROWS];
    logic [7:0]        lane_q [LANES];

    logic [LANES-1:0]  lane_en;
    logic [ROW_IW-1:0] lane_row [LANES];
    logic [7:0]        lane_wdata [LANES];
    logic [DEPTH_LOG2-1:0] wa, ra;

    logic              pop;
    logic              s1_adv;
    logic              s1_valid_reg;
    entry_t            s1_entry_reg;

    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [DATA_W-1:0] out_rdata_reg, rdata_next;
    logic [OFF_W-1:0]  out_r1_off_reg;
    logic [SIZE_W-1:0] out_r1_size_reg;
    logic [SIZE_W-1:0] out_r2_size_reg;

    function automatic logic [DEPTH_LOG2-1:0] byte_addr(entry_t e, int i);
        return (DEPTH_LOG2'(e.start) + DEPTH_LOG2'(i)) & DEPTH_LOG2'(e.mask);
    endfunction

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign head_ready = !s1_valid_reg || s1_adv;
    assign pop        = head_valid && head_ready;

    // steer each byte of the chunk to its lane and row
    always_comb
    begin
        wa      = '0;
        lane_en = '0;
        for (int j = 0; j < LANES; j++)
        begin
            lane_row[j]   = '0;
            lane_wdata[j] = '0;
        end
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            if (head.op != OP_NONE && CNT_W'(i) < head.count)
            begin
                wa = byte_addr(head, i);
                lane_en[wa[LANE_LOG2-1:0]]    = 1'b1;
                lane_row[wa[LANE_LOG2-1:0]]   = ROW_IW'(wa >> LANE_LOG2);
                lane_wdata[wa[LANE_LOG2-1:0]] = head.wdata[8*i +: 8];
            end
        end
    end

    // lane RAMs: one write or one registered read per lane per word
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < LANES; j++)
        begin
            if (pop && lane_en[j])
            begin
                if (head.op == OP_WRITE)
                    mem[j][lane_row[j]] <= lane_wdata[j];
                else if (head.op == OP_READ)
                    lane_q[j] <= mem[j][lane_row[j]];
            end
        end
    end

    // access stage, waits for the read data to come back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (head_ready)
            s1_valid_reg <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_entry_reg <= head;
    end

    // gather read bytes back into chunk order
    always_comb
    begin
        ra         = '0;
        rdata_next = '0;
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            if (s1_entry_reg.op == OP_READ && CNT_W'(i) < s1_entry_reg.count)
            begin
                ra = byte_addr(s1_entry_reg, i);
                rdata_next[8*i +: 8] = lane_q[ra[LANE_LOG2-1:0]];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_ok_reg      <= s1_entry_reg.ok;
            out_rdata_reg   <= rdata_next;
            out_r1_off_reg  <= s1_entry_reg.r1_off;
            out_r1_size_reg <= s1_entry_reg.r1_size;
            out_r2_size_reg <= s1_entry_reg.r2_size;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.read_data      = out_rdata_reg;
    assign rsp.region1_offset = out_r1_off_reg;
    assign rsp.region1_size   = out_r1_size_reg;
    assign rsp.region2_size   = out_r2_size_reg;

    a_lane_per_byte: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.op != OP_NONE |-> $countones(lane_en) == int'(head.count))
        else $error("two bytes of one chunk mapped to the same lane");

    a_move_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.op != OP_NONE |-> head.ok && head.count != '0)
        else $error("memory operation issued for a failed or empty request");

endmodule

// ----- sv/byte_ring_buffer_channel.sv -----
// channel   dir  handshake        payload
// req       in   valid / ready    req_type, byte_count, write_data
// rsp       out  valid / ready    ok, read_data, region1_offset/size, region2_size
// cfg       in   cfg_wr_en        cfg_wr_data (size_log2)
//
// One word per cycle sustained while rsp is not stalled; each result is registered
// through the queue, the lane RAM access and the result register, in that order.
// Each ring byte lives in one of up to eight lane RAMs, so a whole chunk is one RAM access.
// Reset clears positions and sets size_log2 to 12; ring contents are not cleared.
// req.ready drops only when the two-entry queue is full behind a stalled rsp.
module byte_ring_buffer_channel #(
    parameter int DEPTH_LOG2  = 12,
    parameter int CHUNK_BYTES = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [brb_pkg::CFG_W-1:0]  cfg_wr_data,
    brb_req_if.sink                    req,
    brb_rsp_if.source                  rsp
);
    import brb_pkg::*;

    logic   push_valid, push_ready;
    entry_t push_entry;
    logic   head_valid, head_ready;
    entry_t head;

    // accept and classify
    brb_front #(
        .DEPTH_LOG2  (DEPTH_LOG2),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    // decoupling queue
    brb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (head_valid),
        .out_ready (head_ready),
        .out_entry (head)
    );

    // ring memory and result
    brb_back #(
        .DEPTH_LOG2  (DEPTH_LOG2),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head       (head),
        .rsp        (rsp)
    );

endmodule

// ----- tb/sv/brb_ring_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, result and size-register ports of the ring channel,
// keeps its own copy of the ring and both positions, and checks every result
// word in order against the one predicted when its request word was taken.
module brb_ring_checker
    import brb_pkg::*;
#(
    parameter int DEPTH_LOG2  = 12,
    parameter int CHUNK_BYTES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    brb_req_if               req,
    brb_rsp_if               rsp,
    output int               results_due,
    output int               mismatch_count
);

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] read_data;
        logic [OFF_W-1:0]  r1_off;
        logic [SIZE_W-1:0] r1_size;
        logic [SIZE_W-1:0] r2_size;
    } ring_result_t;

    logic [7:0]       ring_mem [2**DEPTH_LOG2];
    logic [31:0]      rd_pos;
    logic [31:0]      wr_pos;
    logic [CFG_W-1:0] size_reg;
    ring_result_t     pending_results [$];

    // contents are never read before written; zero keeps a slip visible
    initial foreach (ring_mem[i]) ring_mem[i] = '0;

    // serve one request word against the shadow ring, return its result word
    function automatic ring_result_t apply_request(input req_type_t kind,
                                                   input logic [COUNT_W-1:0] cnt,
                                                   input logic [DATA_W-1:0] wdat);
        ring_result_t r;
        int unsigned  lg;
        logic [31:0]  ring_len;
        logic [31:0]  mask;
        logic [31:0]  used;
        logic [31:0]  room;
        logic [31:0]  avail;
        logic [31:0]  pos;
        logic [31:0]  to_end;
        logic [31:0]  first;
        r  = '0;
        lg = size_reg;
        if (lg < 1)
            lg = 1;
        if (lg > DEPTH_LOG2)
            lg = DEPTH_LOG2;
        ring_len = 32'd1 << lg;
        mask     = ring_len - 1;
        used     = wr_pos - rd_pos;
        room     = ring_len - used;
        case (kind)
            REQ_WRITE:
            begin
                if (cnt == 0)
                    r.ok = 1'b1;
                else if (cnt <= CHUNK_BYTES && cnt <= room)
                begin
                    for (int i = 0; i < int'(cnt); i++)
                        ring_mem[(wr_pos + i) & mask] = wdat[8*i +: 8];
                    wr_pos += cnt;
                    r.ok = 1'b1;
                end
            end
            REQ_READ:
            begin
                if (cnt == 0)
                    r.ok = 1'b1;
                else if (cnt <= CHUNK_BYTES && cnt <= used)
                begin
                    for (int i = 0; i < int'(cnt); i++)
                        r.read_data[8*i +: 8] = ring_mem[(rd_pos + i) & mask];
                    rd_pos += cnt;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                // describe: split at the ring end, positions stay put
                avail = (kind == REQ_DESC_READ) ? used : room;
                pos   = (kind == REQ_DESC_READ) ? rd_pos : wr_pos;
                if (cnt <= avail)
                begin
                    to_end    = ring_len - (pos & mask);
                    first     = (cnt < to_end) ? cnt : to_end;
                    r.ok      = 1'b1;
                    r.r1_off  = OFF_W'(pos & mask);
                    r.r1_size = SIZE_W'(first);
                    r.r2_size = SIZE_W'(cnt - first);
                end
            end
        endcase
        return r;
    endfunction

    // predict on each request word, compare on each result word
    always @(posedge clk or negedge rst_n)
    begin : track
        ring_result_t got;
        ring_result_t want;
        if (!rst_n)
        begin
            rd_pos         = '0;
            wr_pos         = '0;
            size_reg       = SIZE_LOG2_RESET;
            pending_results.delete();
            mismatch_count = 0;
            results_due   <= 0;
        end
        else
        begin
            // a size write rebinds the ring
            if (cfg_wr_en)
            begin
                size_reg = cfg_wr_data;
                rd_pos   = '0;
                wr_pos   = '0;
            end
            if (req.valid && req.ready)
                pending_results.push_back(apply_request(req_type_t'(req.req_type),
                                                        req.byte_count, req.write_data));
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.ok, rsp.read_data, rsp.region1_offset,
                        rsp.region1_size, rsp.region2_size};
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result word with nothing expected: ok=%0b data=%h",
                                 $realtime, got.ok, got.read_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("[%0t] mismatch: expected ok=%0b data=%h off=%0d r1=%0d r2=%0d",
                                     $realtime, want.ok, want.read_data, want.r1_off,
                                     want.r1_size, want.r2_size);
                            $display("[%0t]           actual   ok=%0b data=%h off=%0d r1=%0d r2=%0d",
                                     $realtime, got.ok, got.read_data, got.r1_off,
                                     got.r1_size, got.r2_size);
                        end
                    end
                end
            end
            results_due <= pending_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_byte_ring_buffer_channel.sv -----
`timescale 1ns / 100ps

module tb_byte_ring_buffer_channel;
    import brb_pkg::*;

    localparam int DEPTH_LOG2   = 12;
    localparam int CHUNK_BYTES  = 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_WORDS  = 60;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    int               results_due;
    int               mismatch_count;
    int               burst_left;
    int               phase_sizes [11] = '{3, 1, 8, 15, 2, 5, 12, 4, 6, 0, 7};

    brb_req_if req_if ();
    brb_rsp_if rsp_if ();

    byte_ring_buffer_channel #(
        .DEPTH_LOG2  (DEPTH_LOG2),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if)
    );

    brb_ring_checker #(
        .DEPTH_LOG2  (DEPTH_LOG2),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req            (req_if),
        .rsp            (rsp_if),
        .results_due    (results_due),
        .mismatch_count (mismatch_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // push one request word; bursts of random length with random gaps
    task automatic send_word(input req_type_t kind, input logic [COUNT_W-1:0] cnt,
                             input logic [DATA_W-1:0] wdat);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(30, 80);
            else
            begin
                gap        = $urandom_range(0, 7);
                burst_left = $urandom_range(1, 12);
            end
        end
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.byte_count <= cnt;
        req_if.write_data <= wdat;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        burst_left--;
    endtask

    // stop sending and wait until every result word has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_ring_size(input logic [CFG_W-1:0] val);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        burst_left  = 0;
    endtask

    // random traffic at one ring size: mostly reads and writes in
    // fill-leaning, drain-leaning or balanced runs, some describes, some junk counts
    task automatic run_phase(input logic [CFG_W-1:0] size_val, input int words);
        int unsigned        lg;
        int unsigned        ring_len;
        int unsigned        pick;
        int unsigned        bias;
        int unsigned        wr_share;
        req_type_t          kind;
        logic [COUNT_W-1:0] cnt;
        set_ring_size(size_val);
        lg       = (size_val < 1) ? 1 : ((size_val > DEPTH_LOG2) ? DEPTH_LOG2 : size_val);
        ring_len = 1 << lg;
        bias     = 2;
        for (int n = 0; n < words; n++)
        begin
            if (n % 16 == 0)
                bias = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                kind = req_type_t'($urandom_range(0, 3));
                cnt  = COUNT_W'($urandom_range(0, 8191));
            end
            else if (pick < 28)
            begin
                kind = $urandom_range(0, 1) ? REQ_DESC_READ : REQ_DESC_WRITE;
                cnt  = COUNT_W'($urandom_range(0, ring_len + 2));
            end
            else
            begin
                wr_share = (bias == 0) ? 8 : ((bias == 1) ? 2 : 5);
                kind = ($urandom_range(0, 9) < wr_share) ? REQ_WRITE : REQ_READ;
                cnt  = ($urandom_range(0, 9) == 0) ? '0
                                                   : COUNT_W'($urandom_range(1, CHUNK_BYTES));
            end
            send_word(kind, cnt, {$urandom(), $urandom()});
        end
    endtask

    // stall watchdog: too long with no word moving on either side
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle = 0;
            else
                idle++;
        end
        $display("** byte_ring_buffer_channel: FAILED **");
        $finish;
    end

    // result side stalls on a rotating pattern, with fully open stretches
    initial
    begin : rsp_stall
        logic [15:0] pat;
        int          span;
        wait (rst_n === 1'b1);
        forever
        begin
            span = $urandom_range(24, 160);
            if ($urandom_range(0, 3) == 0)
                pat = '1;
            else
            begin
                pat = 16'($urandom());
                if (pat == '0)
                    pat = 16'h8001;
            end
            repeat (span)
            begin
                @(posedge clk);
                rsp_if.ready <= pat[0];
                pat = {pat[0], pat[15:1]};
            end
        end
    end

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_WRITE;
        req_if.byte_count <= '0;
        req_if.write_data <= '0;
        rsp_if.ready      <= 1'b0;
        burst_left         = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // full-size ring straight out of reset
        send_word(REQ_WRITE, 13'd0, '1);
        send_word(REQ_READ, 13'd0, '0);
        send_word(REQ_READ, 13'd1, '0);            // empty ring
        send_word(REQ_DESC_READ, 13'd0, '0);
        send_word(REQ_DESC_READ, 13'd1, '0);       // nothing to describe
        send_word(REQ_DESC_WRITE, 13'd4096, '0);   // whole ring free
        send_word(REQ_DESC_WRITE, 13'd4097, '0);
        send_word(REQ_DESC_WRITE, 13'd8191, '0);
        send_word(REQ_WRITE, 13'd8, '1);
        send_word(REQ_WRITE, 13'd9, '1);           // above chunk
        send_word(REQ_WRITE, 13'd8191, '1);
        send_word(REQ_READ, 13'd9, '0);            // above chunk
        send_word(REQ_WRITE, 13'd8, '0);
        send_word(REQ_DESC_READ, 13'd16, '0);
        send_word(REQ_READ, 13'd8, '0);
        send_word(REQ_READ, 13'd8, '1);
        send_word(REQ_READ, 13'd1, '0);
        send_word(REQ_WRITE, 13'd3, 64'h0123_4567_89AB_CDEF);
        send_word(REQ_READ, 13'd8, '0);            // not enough data
        send_word(REQ_READ, 13'd3, '0);

        // size 0 acts as a two-byte ring: fill, wrap, split describe
        set_ring_size(4'd0);
        send_word(REQ_WRITE, 13'd1, 64'hA5);
        send_word(REQ_READ, 13'd1, '0);
        send_word(REQ_WRITE, 13'd2, 64'h3C5A);
        send_word(REQ_WRITE, 13'd1, '1);           // ring full
        send_word(REQ_DESC_READ, 13'd2, '0);       // wraps across the end
        send_word(REQ_DESC_WRITE, 13'd0, '0);
        send_word(REQ_DESC_WRITE, 13'd1, '0);
        send_word(REQ_READ, 13'd2, '0);

        foreach (phase_sizes[p])
            run_phase(CFG_W'(phase_sizes[p]), PHASE_WORDS);

        wait_drained();
        if (mismatch_count == 0)
            $display("** byte_ring_buffer_channel: PASSED **");
        else
            $display("** byte_ring_buffer_channel: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
sv/brb_pkg.sv
sv/brb_if.sv
sv/brb_front.sv
sv/brb_queue.sv
sv/brb_back.sv
sv/byte_ring_buffer_channel.sv
tb/sv/brb_ring_checker.sv
tb/sv/tb_byte_ring_buffer_channel.sv
